@@ hw/rtl/cdt_pkg.sv @@
package cdt_pkg;

    localparam int TICK_W   = 32;
    localparam int IDX_W    = 3;
    localparam int OP_W     = 2;
    localparam int MAX_FIRE = 8;
    localparam int CNT_W    = 4;

    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
    localparam logic [OP_W-1:0] OP_ANALYZE = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic              alarm;
    } t_cell;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            may_fire;
    } t_pe_ctrl;

endpackage

@@ hw/rtl/countdown_timer_bank_core.sv @@
// Channel   Direction  Handshake            Word
// command   in         start, busy          i_op, i_timer_index, i_duration
// result    out        o_result_valid       o_fired, o_fired_index, o_last
//
// A command is taken when start is high and busy is low.
// Each command rotates the timer ring once through one update unit at the head,
// then enters a closing cycle; a new command can be taken in that closing cycle.
// An alarm report is held until the next alarm is found or the closing cycle, then
// registered; the final word is on the ports in the cycle after the closing cycle.
// Each word is shown for one cycle, the receiver cannot stall, and reset clears all timers.
module countdown_timer_bank_core #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cdt_pkg::OP_W-1:0]     i_op,
    input  logic [cdt_pkg::IDX_W-1:0]    i_timer_index,
    input  logic [cdt_pkg::TICK_W-1:0]   i_duration,
    output logic                         o_result_valid,
    output logic                         o_fired,
    output logic [cdt_pkg::IDX_W-1:0]    o_fired_index,
    output logic                         o_last
);
    import cdt_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = (IW > IDX_W) ? IW : IDX_W;
    localparam logic [IW-1:0] LAST_POS = IW'(NUM_TIMERS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IW-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_held, n_held;
    logic [OP_W-1:0]   r_op, n_op;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [TICK_W-1:0] r_dur, n_dur;
    logic              r_valid, n_valid;
    logic              r_fired, n_fired;
    logic [IDX_W-1:0]  r_fidx, n_fidx;
    logic              r_last, n_last;

    t_cell    w_q   [NUM_TIMERS];
    t_cell    w_d   [NUM_TIMERS];
    t_cell    w_tail;
    t_pe_ctrl w_ctrl;
    logic     w_found;
    logic     w_shift;
    logic     w_take;
    logic [CW-1:0] w_pos_ext;

    assign busy      = (r_state == ST_SCAN);
    assign w_take    = start && !busy;
    assign w_shift   = (r_state == ST_SCAN);
    assign w_pos_ext = CW'(r_pos);

    assign w_ctrl.op       = r_op;
    assign w_ctrl.hit      = (w_pos_ext == CW'(r_idx));
    assign w_ctrl.may_fire = (r_cnt < CNT_W'(MAX_FIRE));

    cdt_pe u_pe (
        .i_head     (w_q[0]),
        .i_ctrl     (w_ctrl),
        .i_duration (r_dur),
        .o_cell     (w_tail),
        .o_found    (w_found)
    );

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        if (g == NUM_TIMERS - 1) begin : g_tail
            assign w_d[g] = w_tail;
        end else begin : g_link
            assign w_d[g] = w_q[g+1];
        end
        cdt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_shift),
            .i_d     (w_d[g]),
            .o_q     (w_q[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_held  = r_held;
        n_op    = r_op;
        n_idx   = r_idx;
        n_dur   = r_dur;
        n_valid = 1'b0;
        n_fired = 1'b0;
        n_fidx  = '0;
        n_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
            end
            ST_SCAN: begin
                n_pos = r_pos + 1'b1;
                if (w_found) begin
                    if (r_cnt != '0) begin
                        n_valid = 1'b1;
                        n_fired = 1'b1;
                        n_fidx  = r_held;
                    end
                    n_held = w_pos_ext[IDX_W-1:0];
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_pos == LAST_POS) begin
                    n_pos   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_fired = (r_cnt != '0);
                n_fidx  = (r_cnt != '0) ? r_held : '0;
                n_last  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_take) begin
            n_op    = i_op;
            n_idx   = i_timer_index;
            n_dur   = i_duration;
            n_pos   = '0;
            n_cnt   = '0;
            n_held  = '0;
            n_state = ST_SCAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_dur  <= n_dur;
        r_fired <= n_fired;
        r_fidx <= n_fidx;
        r_last <= n_last;
    end

    assign o_result_valid = r_valid;
    assign o_fired        = r_fired;
    assign o_fired_index  = r_fidx;
    assign o_last         = r_last;

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> busy)
        else $error("Accepted command did not start a scan.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_FIRE))
        else $error("Alarm report count exceeded its limit.");

    a_mid_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> r_fired)
        else $error("A non-final result did not report an alarm.");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_fired) |-> (r_last && (r_fidx == '0)))
        else $error("An empty result was not a final one.");

    a_done_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ($past(r_state) == ST_SCAN))
        else $error("Closing cycle entered without a scan.");

endmodule

@@ hw/rtl/cdt_cell.sv @@
module cdt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cdt_pkg::t_cell i_d,
    output cdt_pkg::t_cell o_q
);
    import cdt_pkg::*;

    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ hw/rtl/cdt_pe.sv @@
module cdt_pe (
    input  cdt_pkg::t_cell               i_head,
    input  cdt_pkg::t_pe_ctrl            i_ctrl,
    input  logic [cdt_pkg::TICK_W-1:0]   i_duration,
    output cdt_pkg::t_cell               o_cell,
    output logic                         o_found
);
    import cdt_pkg::*;

    always_comb begin
        o_cell  = i_head;
        o_found = 1'b0;
        case (i_ctrl.op)
            OP_START: begin
                if (i_ctrl.hit) begin
                    o_cell.ticks = i_duration;
                    o_cell.alarm = 1'b0;
                end
            end
            OP_STOP: begin
                if (i_ctrl.hit) begin
                    o_cell.ticks = '0;
                    o_cell.alarm = 1'b0;
                end
            end
            OP_TICK: begin
                if (i_head.ticks != '0) begin
                    o_cell.ticks = i_head.ticks - 1'b1;
                    if (i_head.ticks == TICK_W'(1)) begin
                        o_cell.alarm = 1'b1;
                    end
                end
            end
            OP_ANALYZE: begin
                if (i_head.alarm && i_ctrl.may_fire) begin
                    o_cell.alarm = 1'b0;
                    o_found      = 1'b1;
                end
            end
            default: begin
                o_cell = i_head;
            end
        endcase
    end

endmodule
